// ----- sv/gtag_pkg.sv -----
// Shared types, constants and GF(2^128) helper functions for the GHASH tag engine.
// No dependencies; imported by every module of the block.
package gtag_pkg;

    localparam int BLOCK_BITS     = 128;
    localparam int HALF_BITS      = 64;
    localparam int DIGIT_BITS     = 32;
    localparam int MUL_STEPS      = BLOCK_BITS / DIGIT_BITS;
    localparam int PROD_BITS      = BLOCK_BITS + DIGIT_BITS;
    localparam int BLOCK_BYTES    = 16;
    localparam int BYTE_BITS      = 8;
    localparam int LEN_SHIFT      = $clog2(BYTE_BITS);
    localparam int NB_BITS        = 5;
    localparam int COUNT_BITS_DEF = 36;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_INDEX_BITS = 2;

    // Reduction taps of x^128 = x^7 + x^2 + x + 1
    localparam int RED_TAP_A = 1;
    localparam int RED_TAP_B = 2;
    localparam int RED_TAP_C = 7;

    typedef enum logic [0:0] {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } t_opcode;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_HASH_KEY_HI = 2'd0,
        REG_HASH_KEY_LO = 2'd1
    } t_reg_index;

    // One queued work item, block already masked for absorbs
    typedef struct packed {
        t_opcode                 op;
        logic [BLOCK_BITS-1:0]   blk;
        logic [NB_BITS-1:0]      nbytes;
    } t_item;

    // Commands from the back end to the multiplier
    typedef struct packed {
        logic start;
        logic ack;
    } t_mul_ctl;

    // Map GCM reflected bit order to plain polynomial order (and back)
    function automatic logic [BLOCK_BITS-1:0] bit_reverse(input logic [BLOCK_BITS-1:0] a);
        logic [BLOCK_BITS-1:0] r;
        for (int k = 0; k < BLOCK_BITS; k++) begin
            r[k] = a[BLOCK_BITS-1-k];
        end
        return r;
    endfunction

    // Carry-less product of a 128-bit operand and a 32-bit digit
    function automatic logic [PROD_BITS-1:0] gf_clmul(input logic [BLOCK_BITS-1:0] v,
                                                      input logic [DIGIT_BITS-1:0] d);
        logic [PROD_BITS-1:0] p;
        p = '0;
        for (int j = 0; j < DIGIT_BITS; j++) begin
            if (d[j]) begin
                p = p ^ ({{DIGIT_BITS{1'b0}}, v} << j);
            end
        end
        return p;
    endfunction

    // Fold the bits above degree 127 back in once
    function automatic logic [BLOCK_BITS-1:0] gf_fold(input logic [PROD_BITS-1:0] p);
        logic [BLOCK_BITS-1:0] h;
        h = BLOCK_BITS'(p[PROD_BITS-1:BLOCK_BITS]);
        return p[BLOCK_BITS-1:0] ^ h ^ (h << RED_TAP_A) ^ (h << RED_TAP_B)
               ^ (h << RED_TAP_C);
    endfunction

endpackage

// ----- sv/gtag_front.sv -----
// Input front end: accepts items, drops empty absorbs, clamps and applies the byte mask.
// Depends on gtag_pkg; feeds gtag_queue.
module gtag_front
    import gtag_pkg::*;
(
    input  logic                  i_valid,
    input  logic                  i_opcode,
    input  logic [HALF_BITS-1:0]  i_block_hi,
    input  logic [HALF_BITS-1:0]  i_block_lo,
    input  logic [NB_BITS-1:0]    i_valid_bytes,
    input  logic                  i_full,
    output logic                  o_stall,
    output logic                  o_push,
    output t_item                 o_item
);

    t_opcode               op;
    logic [NB_BITS-1:0]    nbytes;
    logic [BLOCK_BITS-1:0] mask;
    logic                  accept;

    assign op      = t_opcode'(i_opcode);
    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // Clamp oversize counts to a full block
    assign nbytes = (i_valid_bytes > NB_BITS'(BLOCK_BYTES)) ? NB_BITS'(BLOCK_BYTES)
                                                            : i_valid_bytes;

    // Keep leading bytes, byte 0 in the top position
    always_comb begin
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            mask[BLOCK_BITS-1-k*BYTE_BITS -: BYTE_BITS] =
                (NB_BITS'(k) < nbytes) ? {BYTE_BITS{1'b1}} : {BYTE_BITS{1'b0}};
        end
    end

    // Classify: an absorb with no bytes never enters the queue
    always_comb begin
        o_item.op     = op;
        o_item.nbytes = nbytes;
        if (op == OP_FINISH) begin
            o_item.blk = {i_block_hi, i_block_lo};
            o_push     = accept;
        end else begin
            o_item.blk = {i_block_hi, i_block_lo} & mask;
            o_push     = accept && (nbytes != '0);
        end
    end

endmodule

// ----- sv/gtag_queue.sv -----
// Short item queue between the front end and the hash back end.
// Depends on gtag_pkg for the item type and depth.
module gtag_queue
    import gtag_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_item                r_slot [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr;
    logic [CNT_BITS-1:0]  r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/gtag_mul.sv -----
// Digit-serial GF(2^128) multiplier: 32 key bits per cycle, the whole key used for each product.
// Depends on gtag_pkg for gf_clmul and gf_fold; operands in plain polynomial order.
module gtag_mul
    import gtag_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mul_ctl              i_ctl,
    input  logic [BLOCK_BITS-1:0] i_x,
    input  logic [BLOCK_BITS-1:0] i_key,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [BLOCK_BITS-1:0] o_z
);

    localparam int STEP_BITS = $clog2(MUL_STEPS + 1);
    localparam int IDX_BITS  = $clog2(MUL_STEPS);

    logic [BLOCK_BITS-1:0] r_v;
    logic [BLOCK_BITS-1:0] r_z;
    logic [STEP_BITS-1:0]  r_cnt;
    logic                  r_run;

    logic [BLOCK_BITS-1:0] src_v;
    logic [BLOCK_BITS-1:0] src_z;
    logic [IDX_BITS-1:0]   idx;
    logic [DIGIT_BITS-1:0] digit;
    logic [BLOCK_BITS-1:0] n_v;
    logic [BLOCK_BITS-1:0] n_z;
    logic                  step_en;

    assign o_busy = r_run;
    assign o_done = r_run && (r_cnt == STEP_BITS'(MUL_STEPS));
    assign o_z    = r_z;

    // One step: add V times the current key digit, then move V up by x^32
    assign src_v   = i_ctl.start ? i_x : r_v;
    assign src_z   = i_ctl.start ? '0 : r_z;
    assign idx     = i_ctl.start ? '0 : r_cnt[IDX_BITS-1:0];
    assign digit   = i_key[idx*DIGIT_BITS +: DIGIT_BITS];
    assign n_z     = src_z ^ gf_fold(gf_clmul(src_v, digit));
    assign n_v     = gf_fold({src_v, {DIGIT_BITS{1'b0}}});
    assign step_en = i_ctl.start || (r_run && (r_cnt != STEP_BITS'(MUL_STEPS)));

    // Operand and partial product
    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_v <= n_v;
            r_z <= n_z;
        end
    end

    // Step counter: start runs the first digit, ack frees the unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_run <= 1'b1;
            r_cnt <= STEP_BITS'(1);
        end else if (i_ctl.ack) begin
            r_run <= 1'b0;
        end else if (step_en) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

// ----- sv/gtag_back.sv -----
// Hash back end: accumulator, byte counter, finish handling and tag output register.
// Depends on gtag_pkg; instantiates gtag_mul; pops items from gtag_queue.
module gtag_back
    import gtag_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [BLOCK_BITS-1:0] i_key,
    input  t_item                 i_item,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [HALF_BITS-1:0]  o_tag_hi,
    output logic [HALF_BITS-1:0]  o_tag_lo,
    output logic                  o_length_overflow
);

    logic [BLOCK_BITS-1:0]   r_acc;
    logic [COUNT_BITS-1:0]   r_count;
    logic                    r_ovf;
    t_opcode                 r_op;
    logic [BLOCK_BITS-1:0]   r_mask;
    logic                    r_ovf_pend;
    logic                    r_out_valid;
    logic [BLOCK_BITS-1:0]   r_tag;
    logic                    r_tag_ovf;

    t_mul_ctl                mul_ctl;
    logic                    mul_busy;
    logic                    mul_done;
    logic [BLOCK_BITS-1:0]   mul_z;
    logic [BLOCK_BITS-1:0]   z_word;
    logic                    out_free;
    logic                    consume;
    logic [BLOCK_BITS-1:0]   acc_src;
    logic [BLOCK_BITS-1:0]   len_word;
    logic [BLOCK_BITS-1:0]   addend;
    logic [BLOCK_BITS-1:0]   mul_x;
    logic [COUNT_BITS:0]     count_sum;

    gtag_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_x     (mul_x),
        .i_key   (i_key),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_z     (mul_z)
    );

    assign z_word   = bit_reverse(mul_z);
    assign out_free = !r_out_valid || !i_stall;

    // Retire a finished product; a tag waits for a free output register
    assign consume = mul_done && ((r_op == OP_ABSORB) || out_free);
    assign o_pop   = !i_empty && (!mul_busy || consume);

    // Forward the retiring product straight into the next operand
    assign acc_src  = consume ? ((r_op == OP_FINISH) ? '0 : z_word) : r_acc;
    assign len_word = BLOCK_BITS'({r_count, {LEN_SHIFT{1'b0}}});
    assign addend   = (i_item.op == OP_FINISH) ? len_word : i_item.blk;
    assign mul_x    = bit_reverse(acc_src ^ addend);

    assign mul_ctl.start = o_pop;
    assign mul_ctl.ack   = consume && !o_pop;

    assign count_sum = {1'b0, r_count} + (COUNT_BITS + 1)'(i_item.nbytes);

    // Accumulator, counter and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_op    <= OP_ABSORB;
        end else begin
            r_acc <= acc_src;
            if (o_pop) begin
                r_op <= i_item.op;
                if (i_item.op == OP_FINISH) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else if (count_sum[COUNT_BITS]) begin
                    r_count <= '1;
                    r_ovf   <= 1'b1;
                end else begin
                    r_count <= count_sum[COUNT_BITS-1:0];
                end
            end
        end
    end

    // Hold the tag mask and the message's overflow flag while the product runs
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mask     <= i_item.blk;
            r_ovf_pend <= r_ovf;
        end
    end

    // Output register: load the tag, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && (r_op == OP_FINISH)) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && (r_op == OP_FINISH)) begin
            r_tag     <= z_word ^ r_mask;
            r_tag_ovf <= r_ovf_pend;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_tag_hi          = r_tag[BLOCK_BITS-1:HALF_BITS];
    assign o_tag_lo          = r_tag[HALF_BITS-1:0];
    assign o_length_overflow = r_tag_ovf;

endmodule

// ----- sv/ghash_tag_engine.sv -----
// Top level of the GHASH tag engine: key registers, front end, queue and hash back end.
// Depends on gtag_pkg, gtag_front, gtag_queue and gtag_back.
//
// GHASH for GCM with the hash key H written through the configuration port (index 0 upper
// half, index 1 lower half; other indexes are ignored, the port is always ready). Absorb
// items (opcode 0) are masked to valid_bytes and folded into the accumulator; absorbs with
// zero valid bytes are dropped at the front end. A finish item (opcode 1) hashes the length
// block, XORs in the item's block as the tag mask and returns one tag, then clears the
// message state. Items are accepted into a two-entry queue in any cycle it has room, also
// while a tag waits at the output. The multiplier works through H in 32-bit digits, so the
// hash core takes a new item only once the product for the last one retires, a limit set
// by the accumulator feedback through that multiplier. A finish item passes through the
// queue, the multiplier and the tag output register before its tag appears at the output.
module ghash_tag_engine
    import gtag_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // item input
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_opcode,
    input  logic [HALF_BITS-1:0]      i_block_hi,
    input  logic [HALF_BITS-1:0]      i_block_lo,
    input  logic [NB_BITS-1:0]        i_valid_bytes,
    // tag output
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [HALF_BITS-1:0]      o_tag_hi,
    output logic [HALF_BITS-1:0]      o_tag_lo,
    output logic                      o_length_overflow,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [HALF_BITS-1:0]      i_cfg_data
);

    logic [HALF_BITS-1:0]  r_key_hi;
    logic [HALF_BITS-1:0]  r_key_lo;
    logic [BLOCK_BITS-1:0] key_poly;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    t_item                 push_item;
    t_item                 head_item;

    assign o_cfg_ready = 1'b1;

    // Hash key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_HASH_KEY_HI: r_key_hi <= i_cfg_data;
                REG_HASH_KEY_LO: r_key_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign key_poly = bit_reverse({r_key_hi, r_key_lo});

    gtag_front u_front (
        .i_valid       (i_valid),
        .i_opcode      (i_opcode),
        .i_block_hi    (i_block_hi),
        .i_block_lo    (i_block_lo),
        .i_valid_bytes (i_valid_bytes),
        .i_full        (q_full),
        .o_stall       (o_stall),
        .o_push        (q_push),
        .o_item        (push_item)
    );

    gtag_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (head_item)
    );

    gtag_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_key             (key_poly),
        .i_item            (head_item),
        .i_empty           (q_empty),
        .o_pop             (q_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_tag_hi          (o_tag_hi),
        .o_tag_lo          (o_tag_lo),
        .o_length_overflow (o_length_overflow)
    );

endmodule
